// ===== src/rotation_matrix_from_euler_angles_core_defines.svh =====
// ----------------------------------------------------------------------------
// Rotation matrix core assertion macros
// Shared property macros for the checker of the rotation matrix core.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_FROM_EULER_ANGLES_CORE_DEFINES_SVH
`define ROTATION_MATRIX_FROM_EULER_ANGLES_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix package
// Widths, fixed-point constants, types and tables shared by the core.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int ELEMENT_BITS = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int NSTEPS       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int AW = 36;   // scaled, negated angle in Q30
    localparam int CW = 33;   // CORDIC x, y, z
    localparam int MW = 32;   // multiplier operand
    localparam int RW = 33;   // rounded product
    localparam int SW = 35;   // sum of two signed terms

    localparam int     ELEM_LIM = 1 << (ELEMENT_BITS - 2);
    localparam int     ELEM_SH  = 30 - (ELEMENT_BITS - 2);
    localparam longint ELEM_RND = (ELEM_SH > 0) ?
                                  (longint'(1) << ((ELEM_SH > 0) ? ELEM_SH - 1 : 0)) : 0;

    localparam logic signed [AW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [AW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [MW-1:0] Q30_ONE     = 32'sd1073741824;

    localparam logic [2:0] ORD_XYZ      = 3'd0;
    localparam logic [2:0] ORD_XZY      = 3'd1;
    localparam logic [2:0] ORD_YXZ      = 3'd2;
    localparam logic [2:0] ORD_YZX      = 3'd3;
    localparam logic [2:0] ORD_ZXY      = 3'd4;
    localparam logic [2:0] ORD_ZYX      = 3'd5;
    localparam logic [2:0] ORD_IDENT_LO = 3'd6;
    localparam logic [2:0] ORD_IDENT_HI = 3'd7;

    // Term signs.
    localparam logic POS = 1'b0;
    localparam logic NEG = 1'b1;

    // Operand codes for the product selection.
    localparam logic [2:0] OP_Z  = 3'd0;
    localparam logic [2:0] OP_O  = 3'd1;
    localparam logic [2:0] OP_SX = 3'd2;
    localparam logic [2:0] OP_CX = 3'd3;
    localparam logic [2:0] OP_SY = 3'd4;
    localparam logic [2:0] OP_CY = 3'd5;
    localparam logic [2:0] OP_SZ = 3'd6;
    localparam logic [2:0] OP_CZ = 3'd7;

    typedef logic signed [CW-1:0]           cw_t;
    typedef logic signed [MW-1:0]           mw_t;
    typedef logic signed [ELEMENT_BITS-1:0] elem_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] ord;
        logic [2:0] flip;
        cw_t [2:0]  x;
        cw_t [2:0]  y;
        cw_t [2:0]  z;
    } crd_t;

    typedef struct packed {
        cw_t  z;
        logic flip;
    } red_t;

    // Element = (+/-) a0*a1 (+/-) (b0*b1)*b2
    typedef struct packed {
        logic       sa;
        logic [2:0] a0;
        logic [2:0] a1;
        logic       sb;
        logic [2:0] b0;
        logic [2:0] b1;
        logic [2:0] b2;
    } plan_t;

    function automatic cw_t atan_q30(input logic [4:0] i);
        cw_t t;
        case (i)
            5'd0:  t = 33'sd843314856;
            5'd1:  t = 33'sd497837829;
            5'd2:  t = 33'sd263043836;
            5'd3:  t = 33'sd133525158;
            5'd4:  t = 33'sd67021686;
            5'd5:  t = 33'sd33543515;
            5'd6:  t = 33'sd16775850;
            5'd7:  t = 33'sd8388437;
            5'd8:  t = 33'sd4194282;
            5'd9:  t = 33'sd2097149;
            5'd10: t = 33'sd1048575;
            5'd11: t = 33'sd524287;
            5'd12: t = 33'sd262143;
            5'd13: t = 33'sd131071;
            5'd14: t = 33'sd65535;
            5'd15: t = 33'sd32767;
            5'd16: t = 33'sd16383;
            5'd17: t = 33'sd8191;
            5'd18: t = 33'sd4095;
            5'd19: t = 33'sd2047;
            5'd20: t = 33'sd1023;
            5'd21: t = 33'sd511;
            5'd22: t = 33'sd255;
            5'd23: t = 33'sd127;
            5'd24: t = 33'sd63;
            5'd25: t = 33'sd31;
            5'd26: t = 33'sd15;
            5'd27: t = 33'sd8;
            5'd28: t = 33'sd4;
            5'd29: t = 33'sd2;
            5'd30: t = 33'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Moving axes run the reversed order.
    function automatic logic [2:0] rev_order(input logic [2:0] o);
        logic [2:0] r;
        case (o)
            ORD_XYZ: r = ORD_ZYX;
            ORD_XZY: r = ORD_YZX;
            ORD_YXZ: r = ORD_ZXY;
            ORD_YZX: r = ORD_XZY;
            ORD_ZXY: r = ORD_YXZ;
            ORD_ZYX: r = ORD_XYZ;
            default: r = o;
        endcase
        return r;
    endfunction

    // Bring the angle into [-pi/2, pi/2]; flip marks a half-turn shift.
    function automatic red_t reduce(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] w;
        red_t                 r;
        w = a;
        if (w > Q30_PI)
            w = w - Q30_TWO_PI;
        else if (w < -Q30_PI)
            w = w + Q30_TWO_PI;
        r.flip = 1'b0;
        if (w > Q30_HALF_PI)
        begin
            w      = w - Q30_PI;
            r.flip = 1'b1;
        end
        else if (w < -Q30_HALF_PI)
        begin
            w      = w + Q30_PI;
            r.flip = 1'b1;
        end
        r.z = w[CW-1:0];
        return r;
    endfunction

    function automatic plan_t mk(input logic sa, input logic [2:0] a0, input logic [2:0] a1,
                                 input logic sb, input logic [2:0] b0, input logic [2:0] b1,
                                 input logic [2:0] b2);
        plan_t p;
        p = '{sa, a0, a1, sb, b0, b1, b2};
        return p;
    endfunction

    function automatic plan_t two(input logic sa, input logic [2:0] a0, input logic [2:0] a1);
        return mk(sa, a0, a1, POS, OP_Z, OP_Z, OP_Z);
    endfunction

    // Closed-form products for every order and element.
    function automatic plan_t elem_plan(input logic [2:0] o, input logic [3:0] k);
        plan_t p;
        p = two(POS, OP_Z, OP_Z);
        case (o)
            ORD_XYZ:
                case (k)
                    4'd0: p = two(POS, OP_CY, OP_CZ);
                    4'd1: p = two(POS, OP_CY, OP_SZ);
                    4'd2: p = two(NEG, OP_SY, OP_O);
                    4'd3: p = mk(NEG, OP_CX, OP_SZ, POS, OP_SX, OP_SY, OP_CZ);
                    4'd4: p = mk(POS, OP_CX, OP_CZ, POS, OP_SX, OP_SY, OP_SZ);
                    4'd5: p = two(POS, OP_SX, OP_CY);
                    4'd6: p = mk(POS, OP_SX, OP_SZ, POS, OP_CX, OP_SY, OP_CZ);
                    4'd7: p = mk(NEG, OP_SX, OP_CZ, POS, OP_CX, OP_SY, OP_SZ);
                    4'd8: p = two(POS, OP_CX, OP_CY);
                    default: p = two(POS, OP_Z, OP_Z);
                endcase
            ORD_XZY:
                case (k)
                    4'd0: p = two(POS, OP_CY, OP_CZ);
                    4'd1: p = two(POS, OP_SZ, OP_O);
                    4'd2: p = two(NEG, OP_CZ, OP_SY);
                    4'd3: p = mk(POS, OP_SX, OP_SY, NEG, OP_CX, OP_SZ, OP_CY);
                    4'd4: p = two(POS, OP_CX, OP_CZ);
                    4'd5: p = mk(POS, OP_SX, OP_CY, POS, OP_CX, OP_SY, OP_SZ);
                    4'd6: p = mk(POS, OP_CX, OP_SY, POS, OP_SX, OP_SZ, OP_CY);
                    4'd7: p = two(NEG, OP_SX, OP_CZ);
                    4'd8: p = mk(POS, OP_CX, OP_CY, NEG, OP_SX, OP_SY, OP_SZ);
                    default: p = two(POS, OP_Z, OP_Z);
                endcase
            ORD_YXZ:
                case (k)
                    4'd0: p = mk(POS, OP_CY, OP_CZ, NEG, OP_SX, OP_SY, OP_SZ);
                    4'd1: p = mk(POS, OP_CY, OP_SZ, POS, OP_SX, OP_SY, OP_CZ);
                    4'd2: p = two(NEG, OP_CX, OP_SY);
                    4'd3: p = two(NEG, OP_CX, OP_SZ);
                    4'd4: p = two(POS, OP_CX, OP_CZ);
                    4'd5: p = two(POS, OP_SX, OP_O);
                    4'd6: p = mk(POS, OP_CZ, OP_SY, POS, OP_SX, OP_CY, OP_SZ);
                    4'd7: p = mk(POS, OP_SY, OP_SZ, NEG, OP_SX, OP_CY, OP_CZ);
                    4'd8: p = two(POS, OP_CX, OP_CY);
                    default: p = two(POS, OP_Z, OP_Z);
                endcase
            ORD_YZX:
                case (k)
                    4'd0: p = two(POS, OP_CY, OP_CZ);
                    4'd1: p = mk(POS, OP_SX, OP_SY, POS, OP_CX, OP_CY, OP_SZ);
                    4'd2: p = mk(NEG, OP_CX, OP_SY, POS, OP_CY, OP_SZ, OP_SX);
                    4'd3: p = two(NEG, OP_SZ, OP_O);
                    4'd4: p = two(POS, OP_CX, OP_CZ);
                    4'd5: p = two(POS, OP_CZ, OP_SX);
                    4'd6: p = two(POS, OP_SY, OP_CZ);
                    4'd7: p = mk(NEG, OP_CY, OP_SX, POS, OP_CX, OP_SY, OP_SZ);
                    4'd8: p = mk(POS, OP_CX, OP_CY, POS, OP_SX, OP_SY, OP_SZ);
                    default: p = two(POS, OP_Z, OP_Z);
                endcase
            ORD_ZXY:
                case (k)
                    4'd0: p = mk(POS, OP_CY, OP_CZ, POS, OP_SX, OP_SY, OP_SZ);
                    4'd1: p = two(POS, OP_CX, OP_SZ);
                    4'd2: p = mk(NEG, OP_SY, OP_CZ, POS, OP_SX, OP_CY, OP_SZ);
                    4'd3: p = mk(NEG, OP_SZ, OP_CY, POS, OP_SX, OP_SY, OP_CZ);
                    4'd4: p = two(POS, OP_CX, OP_CZ);
                    4'd5: p = mk(POS, OP_SY, OP_SZ, POS, OP_SX, OP_CY, OP_CZ);
                    4'd6: p = two(POS, OP_CX, OP_SY);
                    4'd7: p = two(NEG, OP_SX, OP_O);
                    4'd8: p = two(POS, OP_CX, OP_CY);
                    default: p = two(POS, OP_Z, OP_Z);
                endcase
            ORD_ZYX:
                case (k)
                    4'd0: p = two(POS, OP_CY, OP_CZ);
                    4'd1: p = mk(POS, OP_CX, OP_SZ, POS, OP_CZ, OP_SY, OP_SX);
                    4'd2: p = mk(POS, OP_SX, OP_SZ, NEG, OP_CX, OP_CZ, OP_SY);
                    4'd3: p = two(NEG, OP_SZ, OP_CY);
                    4'd4: p = mk(POS, OP_CX, OP_CZ, NEG, OP_SX, OP_SY, OP_SZ);
                    4'd5: p = mk(POS, OP_SX, OP_CZ, POS, OP_CX, OP_SY, OP_SZ);
                    4'd6: p = two(POS, OP_SY, OP_O);
                    4'd7: p = two(NEG, OP_SX, OP_CY);
                    4'd8: p = two(POS, OP_CX, OP_CY);
                    default: p = two(POS, OP_Z, OP_Z);
                endcase
            default:
                if (k == 4'd0 || k == 4'd4 || k == 4'd8)
                    p = two(POS, OP_O, OP_O);
        endcase
        return p;
    endfunction

    // Q30 product rounding: floor((p + 2^29) / 2^30).
    function automatic logic signed [RW-1:0] rnd_q30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[RW-1:0];
    endfunction

    // Round half up to the element format and saturate to +/-1.0.
    function automatic elem_t to_elem(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + SW'(ELEM_RND)) >>> ELEM_SH;
        if (r > SW'(ELEM_LIM))
            r = SW'(ELEM_LIM);
        if (r < SW'(-ELEM_LIM))
            r = SW'(-ELEM_LIM);
        return r[ELEMENT_BITS-1:0];
    endfunction

endpackage

// ===== src/rme_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step for the three angles, registered toward the next cell.
// ----------------------------------------------------------------------------
module rme_cordic_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic [4:0]    step,
    input  rme_pkg::crd_t d,
    output rme_pkg::crd_t q
);
    import rme_pkg::*;

    crd_t q_reg;
    crd_t q_next;
    logic vld_reg;
    cw_t  t;

    always_comb
    begin
        q_next = d;
        t      = atan_q30(step);
        for (int l = 0; l < 3; l++)
        begin
            if (!d.z[l][CW-1])
            begin
                q_next.x[l] = d.x[l] - ($signed(d.y[l]) >>> step);
                q_next.y[l] = d.y[l] + ($signed(d.x[l]) >>> step);
                q_next.z[l] = d.z[l] - t;
            end
            else
            begin
                q_next.x[l] = d.x[l] + ($signed(d.y[l]) >>> step);
                q_next.y[l] = d.y[l] - ($signed(d.x[l]) >>> step);
                q_next.z[l] = d.z[l] + t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    always_comb
    begin
        q       = q_reg;
        q.valid = vld_reg;
    end

endmodule

// ===== src/rme_matrix.sv =====
// ----------------------------------------------------------------------------
// Matrix product stage
// Forms the nine elements from sines and cosines in three pipeline stages.
// ----------------------------------------------------------------------------
module rme_matrix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  rme_pkg::crd_t       d,
    output logic                valid,
    output rme_pkg::elem_t [8:0] elem
);
    import rme_pkg::*;

    mw_t                  src [8];
    plan_t                pl  [9];
    logic signed [63:0]   pa_next [9];
    logic signed [63:0]   pb_next [9];

    logic signed [63:0]   pa_reg  [9];
    logic signed [63:0]   pb_reg  [9];
    mw_t                  b2_reg  [9];
    logic [8:0]           sa1_reg;
    logic [8:0]           sb1_reg;

    logic signed [RW-1:0] ra_next [9];
    logic signed [RW-1:0] rb1     [9];
    logic signed [63:0]   pc_next [9];
    logic signed [RW-1:0] ra_reg  [9];
    logic signed [63:0]   pc_reg  [9];
    logic [8:0]           sa2_reg;
    logic [8:0]           sb2_reg;

    elem_t [8:0]          elem_next;
    elem_t [8:0]          elem_reg;
    logic [2:0]           vld_reg;

    // Stage 1: undo the half-turn shift, pick operands, first products.
    always_comb
    begin
        src[OP_Z] = '0;
        src[OP_O] = Q30_ONE;
        src[OP_SX] = d.flip[0] ? mw_t'(-d.y[0]) : mw_t'(d.y[0]);
        src[OP_CX] = d.flip[0] ? mw_t'(-d.x[0]) : mw_t'(d.x[0]);
        src[OP_SY] = d.flip[1] ? mw_t'(-d.y[1]) : mw_t'(d.y[1]);
        src[OP_CY] = d.flip[1] ? mw_t'(-d.x[1]) : mw_t'(d.x[1]);
        src[OP_SZ] = d.flip[2] ? mw_t'(-d.y[2]) : mw_t'(d.y[2]);
        src[OP_CZ] = d.flip[2] ? mw_t'(-d.x[2]) : mw_t'(d.x[2]);
        for (int k = 0; k < 9; k++)
        begin
            pl[k]      = elem_plan(d.ord, 4'(k));
            pa_next[k] = src[pl[k].a0] * src[pl[k].a1];
            pb_next[k] = src[pl[k].b0] * src[pl[k].b1];
        end
    end

    // Stage 2: round, second factor of the triple products.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            ra_next[k] = rnd_q30(pa_reg[k]);
            rb1[k]     = rnd_q30(pb_reg[k]);
            pc_next[k] = rb1[k] * b2_reg[k];
        end
    end

    // Stage 3: signed sum, round to the element format, saturate.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            elem_next[k] = to_elem((sa2_reg[k] ? -SW'(ra_reg[k]) : SW'(ra_reg[k]))
                                 + (sb2_reg[k] ? -SW'(rnd_q30(pc_reg[k]))
                                               :  SW'(rnd_q30(pc_reg[k]))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], d.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pa_reg[k]  <= pa_next[k];
                pb_reg[k]  <= pb_next[k];
                b2_reg[k]  <= src[pl[k].b2];
                sa1_reg[k] <= pl[k].sa;
                sb1_reg[k] <= pl[k].sb;
                ra_reg[k]  <= ra_next[k];
                pc_reg[k]  <= pc_next[k];
            end
            sa2_reg  <= sa1_reg;
            sb2_reg  <= sb1_reg;
            elem_reg <= elem_next;
        end
    end

    assign valid = vld_reg[2];
    assign elem  = elem_reg;

endmodule

// ===== src/rotation_matrix_from_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// Euler angles to rotation matrix core
// Turns three angles and an axis order into the nine rotation matrix elements.
// ----------------------------------------------------------------------------
// Usage: a request carries angle_x, angle_y, angle_z (signed Q3.12 radians),
// rotation_order and moving_axes on req_valid; it is taken at a clock edge
// where req_valid is high and req_stall is low. Each request yields exactly
// one result, elem_0_0 through elem_2_2 in signed Q1.14, on res_valid.
// The path runs through one input register, one angle reduction register,
// one cell per CORDIC step, and three product stages ending in the output
// register. Throughput is one request per cycle while no result is held;
// the rate is set by the cell row and the product pipeline, which all move
// together on a single advance signal.
// When the receiver holds res_stall while a result is shown, the whole
// pipeline freezes and req_stall rises in the same cycle, so no result is
// lost or repeated. Reset clears every valid bit; payload registers are not
// reset. req_stall is low out of reset, so a request can be taken at the
// first clock edge after reset is released.
// Order codes 6 and 7 give the identity matrix.
module rotation_matrix_from_euler_angles_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic signed [rme_pkg::ANGLE_BITS-1:0] angle_x,
    input  logic signed [rme_pkg::ANGLE_BITS-1:0] angle_y,
    input  logic signed [rme_pkg::ANGLE_BITS-1:0] angle_z,
    input  logic [2:0]                            rotation_order,
    input  logic                                  moving_axes,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output rme_pkg::elem_t                        elem_0_0,
    output rme_pkg::elem_t                        elem_0_1,
    output rme_pkg::elem_t                        elem_0_2,
    output rme_pkg::elem_t                        elem_1_0,
    output rme_pkg::elem_t                        elem_1_1,
    output rme_pkg::elem_t                        elem_1_2,
    output rme_pkg::elem_t                        elem_2_0,
    output rme_pkg::elem_t                        elem_2_1,
    output rme_pkg::elem_t                        elem_2_2
);
    import rme_pkg::*;

    localparam int PAD = 34 - ANGLE_BITS;

    logic                 adv;
    logic signed [33:0]   sc [3];
    logic signed [AW-1:0] ang_next [3];
    logic signed [AW-1:0] ang_reg  [3];
    logic [2:0]           ord_next;
    logic [2:0]           ord_reg;
    logic [1:0]           vld_reg;
    red_t                 red [3];
    crd_t                 cell_in;
    crd_t                 c0_reg;
    crd_t                 chain [NSTEPS+1];
    elem_t [8:0]          elem;

    // Everything advances unless a finished result is being held.
    assign adv       = !(res_valid && res_stall);
    assign req_stall = !adv;

    // Input stage: scale to Q30, negate and reverse the order in moving mode.
    always_comb
    begin
        sc[0] = {angle_x, {PAD{1'b0}}};
        sc[1] = {angle_y, {PAD{1'b0}}};
        sc[2] = {angle_z, {PAD{1'b0}}};
        for (int l = 0; l < 3; l++)
            ang_next[l] = moving_axes ? -AW'(sc[l]) : AW'(sc[l]);
        ord_next = moving_axes ? rev_order(rotation_order) : rotation_order;
    end

    // Reduction stage feeds the first cell.
    always_comb
    begin
        cell_in       = c0_reg;
        cell_in.valid = vld_reg[1];
        for (int l = 0; l < 3; l++)
            red[l] = reduce(ang_reg[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[0], req_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg      <= ang_next;
            ord_reg      <= ord_next;
            c0_reg.valid <= 1'b0;
            c0_reg.ord   <= ord_reg;
            for (int l = 0; l < 3; l++)
            begin
                c0_reg.flip[l] <= red[l].flip;
                c0_reg.x[l]    <= CORDIC_GAIN;
                c0_reg.y[l]    <= '0;
                c0_reg.z[l]    <= red[l].z;
            end
        end
    end

    assign chain[0] = cell_in;

    // One cell per CORDIC step.
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_cell
        rme_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .step  (5'(i)),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    rme_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .d     (chain[NSTEPS]),
        .valid (res_valid),
        .elem  (elem)
    );

    assign elem_0_0 = elem[0];
    assign elem_0_1 = elem[1];
    assign elem_0_2 = elem[2];
    assign elem_1_0 = elem[3];
    assign elem_1_1 = elem[4];
    assign elem_1_2 = elem[5];
    assign elem_2_0 = elem[6];
    assign elem_2_1 = elem[7];
    assign elem_2_2 = elem[8];

endmodule

// ===== src/rme_checker.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix core checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "rotation_matrix_from_euler_angles_core_defines.svh"

module rme_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_stall,
    input logic           res_valid,
    input logic           res_stall,
    input rme_pkg::elem_t elem_0_0,
    input rme_pkg::elem_t elem_1_1,
    input rme_pkg::elem_t elem_2_2
);
    import rme_pkg::*;

    // Elements 0_0 and 2_2 of a valid result never leave the saturation range.
    `RME_ASSERT_NOW(a_range, res_valid,
        elem_0_0 <= ELEM_LIM && elem_0_0 >= -ELEM_LIM &&
        elem_2_2 <= ELEM_LIM && elem_2_2 >= -ELEM_LIM, "element out of range")

    // A held result stalls the request side in the same cycle.
    `RME_ASSERT_NOW(a_backpressure, res_valid && res_stall, req_stall,
        "request taken while result is held")

    // With no result waiting the block never stalls requests.
    `RME_ASSERT_NOW(a_no_bubble, !res_valid || !res_stall, !req_stall,
        "request stalled without a held result")

    // A held result stays valid and its elements 0_0 and 1_1 stay put.
    `RME_ASSERT_NEXT(a_hold, res_valid && res_stall,
        res_valid && $stable(elem_0_0) && $stable(elem_1_1), "held result changed")

endmodule

bind rotation_matrix_from_euler_angles_core rme_checker u_rme_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix core regression bench
// Drives angle triples with every axis order and both axis modes into the
// core, predicts each matrix with a bit-exact CORDIC and product model of its
// own, and compares every element of every result in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rme_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    // One request as offered to the core.
    typedef struct {
        logic signed [ANGLE_BITS-1:0] ax;
        logic signed [ANGLE_BITS-1:0] ay;
        logic signed [ANGLE_BITS-1:0] az;
        logic [2:0]                   ord;
        logic                         mov;
    } angles_t;

    // One expected matrix, elements in port order.
    typedef struct {
        elem_t e [9];
    } matrix_t;

    logic                         clk;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_stall;
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
    logic [2:0]                   rotation_order;
    logic                         moving_axes;
    logic                         res_valid;
    logic                         res_stall;
    elem_t                        elem_0_0, elem_0_1, elem_0_2;
    elem_t                        elem_1_0, elem_1_1, elem_1_2;
    elem_t                        elem_2_0, elem_2_1, elem_2_2;

    angles_t pending_requests[$];
    matrix_t expected_matrices[$];
    int      mismatch_count;
    int      idle_cycles;
    bit      stimulus_done;
    bit      hold_results;

    // Stall as seen at the last rising edge, the gap drawn for the next
    // request, and whether a result was taken there; all are captured at
    // the rising edge so the negedge processes never race the core.
    logic req_stall_at_edge;
    int   send_gap_next;
    logic res_valid_taken;

    rotation_matrix_from_euler_angles_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .rotation_order(rotation_order), .moving_axes(moving_axes),
        .res_valid(res_valid), .res_stall(res_stall),
        .elem_0_0(elem_0_0), .elem_0_1(elem_0_1), .elem_0_2(elem_0_2),
        .elem_1_0(elem_1_0), .elem_1_1(elem_1_1), .elem_1_2(elem_1_2),
        .elem_2_0(elem_2_0), .elem_2_1(elem_2_1), .elem_2_2(elem_2_2)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction. All arithmetic is carried in 64-bit signed values in Q30,
    // which holds every intermediate with room to spare.
    // ------------------------------------------------------------------
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint GAIN_Q30    = 64'sd652032874;

    longint arctan_steps [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
        8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 8, 4, 2, 1, 0};

    // Rounded Q30 product; >>> on a signed longint is a floor shift.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (ONE_Q30 >>> 1)) >>> 30;
    endfunction

    function automatic longint qmul3(input longint a, input longint b, input longint c);
        return qmul(qmul(a, b), c);
    endfunction

    // Range reduction to [-pi/2, pi/2] followed by the rotation-mode CORDIC.
    function automatic void cordic_sincos(input longint a, output longint s,
                                          output longint c);
        longint x, y, z, nx;
        bit     half_turn;
        int     steps;
        x = GAIN_Q30;
        y = 0;
        half_turn = 0;
        steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
        if (a > PI_Q30)
            a -= TWO_PI_Q30;
        else if (a < -PI_Q30)
            a += TWO_PI_Q30;
        if (a > HALF_PI_Q30)
        begin
            a -= PI_Q30;
            half_turn = 1;
        end
        else if (a < -HALF_PI_Q30)
        begin
            a += PI_Q30;
            half_turn = 1;
        end
        z = a;
        for (int i = 0; i < steps; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_steps[i];
            end
            x = nx;
        end
        if (half_turn)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    // Round half up to the element format and clamp to plus or minus one.
    function automatic elem_t q30_to_element(input longint v);
        longint lim;
        int     sh;
        lim = longint'(1) << (ELEMENT_BITS - 2);
        sh  = 30 - (ELEMENT_BITS - 2);
        if (sh > 0)
            v = (v + (longint'(1) << (sh - 1))) >>> sh;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return elem_t'(v);
    endfunction

    function automatic matrix_t rotation_matrix(input angles_t r);
        longint  ax, ay, az, sx, cx, sy, cy, sz, cz;
        longint  m [9];
        logic [2:0] o;
        matrix_t res;
        ax = longint'(r.ax) <<< (34 - ANGLE_BITS);
        ay = longint'(r.ay) <<< (34 - ANGLE_BITS);
        az = longint'(r.az) <<< (34 - ANGLE_BITS);
        o  = r.ord;
        // Moving axes: negate every angle (the most negative one has no wrap
        // here since it is already widened) and swap to the reversed order.
        if (r.mov)
        begin
            ax = -ax;
            ay = -ay;
            az = -az;
            case (o)
                ORD_XYZ: o = ORD_ZYX;
                ORD_XZY: o = ORD_YZX;
                ORD_YXZ: o = ORD_ZXY;
                ORD_YZX: o = ORD_XZY;
                ORD_ZXY: o = ORD_YXZ;
                ORD_ZYX: o = ORD_XYZ;
                default: o = o;
            endcase
        end
        cordic_sincos(ax, sx, cx);
        cordic_sincos(ay, sy, cy);
        cordic_sincos(az, sz, cz);
        case (o)
            ORD_XYZ:
            begin
                m[0] = qmul(cy, cz); m[1] = qmul(cy, sz); m[2] = -sy;
                m[3] = -qmul(cx, sz) + qmul3(sx, sy, cz);
                m[4] = qmul(cx, cz) + qmul3(sx, sy, sz); m[5] = qmul(sx, cy);
                m[6] = qmul(sx, sz) + qmul3(cx, sy, cz);
                m[7] = -qmul(sx, cz) + qmul3(cx, sy, sz); m[8] = qmul(cx, cy);
            end
            ORD_XZY:
            begin
                m[0] = qmul(cy, cz); m[1] = sz; m[2] = -qmul(cz, sy);
                m[3] = -qmul3(cx, sz, cy) + qmul(sx, sy); m[4] = qmul(cx, cz);
                m[5] = qmul3(cx, sy, sz) + qmul(sx, cy);
                m[6] = qmul3(sx, sz, cy) + qmul(cx, sy); m[7] = -qmul(sx, cz);
                m[8] = -qmul3(sx, sy, sz) + qmul(cx, cy);
            end
            ORD_YXZ:
            begin
                m[0] = qmul(cy, cz) - qmul3(sx, sy, sz);
                m[1] = qmul(cy, sz) + qmul3(sx, sy, cz); m[2] = -qmul(cx, sy);
                m[3] = -qmul(cx, sz); m[4] = qmul(cx, cz); m[5] = sx;
                m[6] = qmul(cz, sy) + qmul3(sx, cy, sz);
                m[7] = qmul(sy, sz) - qmul3(sx, cy, cz); m[8] = qmul(cx, cy);
            end
            ORD_YZX:
            begin
                m[0] = qmul(cy, cz); m[1] = qmul3(cx, cy, sz) + qmul(sx, sy);
                m[2] = qmul3(cy, sz, sx) - qmul(cx, sy);
                m[3] = -sz; m[4] = qmul(cx, cz); m[5] = qmul(cz, sx);
                m[6] = qmul(sy, cz); m[7] = qmul3(cx, sy, sz) - qmul(cy, sx);
                m[8] = qmul3(sx, sy, sz) + qmul(cx, cy);
            end
            ORD_ZXY:
            begin
                m[0] = qmul(cy, cz) + qmul3(sx, sy, sz); m[1] = qmul(cx, sz);
                m[2] = -qmul(sy, cz) + qmul3(sx, cy, sz);
                m[3] = -qmul(sz, cy) + qmul3(sx, sy, cz); m[4] = qmul(cx, cz);
                m[5] = qmul(sy, sz) + qmul3(sx, cy, cz);
                m[6] = qmul(cx, sy); m[7] = -sx; m[8] = qmul(cx, cy);
            end
            ORD_ZYX:
            begin
                m[0] = qmul(cy, cz); m[1] = qmul(cx, sz) + qmul3(cz, sy, sx);
                m[2] = qmul(sx, sz) - qmul3(cx, cz, sy);
                m[3] = -qmul(sz, cy); m[4] = qmul(cx, cz) - qmul3(sx, sy, sz);
                m[5] = qmul(sx, cz) + qmul3(cx, sy, sz);
                m[6] = sy; m[7] = -qmul(sx, cy); m[8] = qmul(cx, cy);
            end
            default:
                // Codes 6 and 7 give the identity in either mode.
                for (int k = 0; k < 9; k++)
                    m[k] = (k % 4 == 0) ? ONE_Q30 : 0;
        endcase
        for (int k = 0; k < 9; k++)
            res.e[k] = q30_to_element(m[k]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input elem_t got, input elem_t want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: takes requests from the pending queue, waits a random gap
    // before each one, and holds the payload until the core takes it.
    // ------------------------------------------------------------------
    int send_gap;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap  <= 0;
        end
        else if (req_valid && !req_stall_at_edge)
        begin
            // The request was taken at the last rising edge.
            if (send_gap_next == 0 && pending_requests.size() > 0)
                present_next();
            else
            begin
                req_valid <= 1'b0;
                send_gap  <= (send_gap_next > 0) ? send_gap_next - 1 : 0;
            end
        end
        else if (!req_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_requests.size() > 0)
                present_next();
        end
    end

    always @(posedge clk)
    begin
        req_stall_at_edge <= req_stall;
        if (req_valid && !req_stall)
            send_gap_next <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
    end

    task automatic present_next();
        angles_t r;
        r = pending_requests.pop_front();
        angle_x        <= r.ax;
        angle_y        <= r.ay;
        angle_z        <= r.az;
        rotation_order <= r.ord;
        moving_axes    <= r.mov;
        req_valid      <= 1'b1;
        expected_matrices.push_back(rotation_matrix(r));
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: after a result is taken, often a stall of random length,
    // plus one long hold-off while requests keep coming.
    // ------------------------------------------------------------------
    int stall_left;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_results)
            res_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (res_stall)
            res_stall <= 1'b0;
        else if (res_valid_taken)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                res_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        matrix_t want;
        elem_t   got [9];
        res_valid_taken <= rst_n && res_valid && !res_stall;
        if (rst_n && res_valid && !res_stall)
        begin
            got = '{elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2,
                    elem_2_0, elem_2_1, elem_2_2};
            if (expected_matrices.size() == 0)
                report_mismatch("result with no request outstanding", elem_0_0, '0);
            else
            begin
                want = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.e[k])
                        report_mismatch($sformatf("element %0d", k), got[k], want.e[k]);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves anything, outside the long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
            || hold_results)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("rotation_matrix_from_euler_angles_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    function automatic logic signed [ANGLE_BITS-1:0] random_angle();
        case ($urandom_range(0, 7))
            0: return ANGLE_BITS'(int'($urandom_range(0, 3)) - 2);
            1: return {1'b1, {(ANGLE_BITS-1){1'b0}}} + ANGLE_BITS'($urandom_range(0, 3));
            2: return {1'b0, {(ANGLE_BITS-1){1'b1}}} - ANGLE_BITS'($urandom_range(0, 3));
            // Near +pi/2 and -pi, where range reduction switches.
            3: return ANGLE_BITS'(int'($urandom_range(0, 8)) + 6430);
            4: return ANGLE_BITS'(-(int'($urandom_range(0, 8)) + 12864));
            default: return ANGLE_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_request(input logic signed [ANGLE_BITS-1:0] x,
                                 input logic signed [ANGLE_BITS-1:0] y,
                                 input logic signed [ANGLE_BITS-1:0] z,
                                 input logic [2:0] o, input logic m);
        angles_t r;
        r = '{x, y, z, o, m};
        pending_requests.push_back(r);
    endtask

    localparam logic signed [ANGLE_BITS-1:0] MOST_NEG = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS-1:0] MOST_POS = {1'b0, {(ANGLE_BITS-1){1'b1}}};

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        res_stall      = 1'b0;
        angle_x        = '0;
        angle_y        = '0;
        angle_z        = '0;
        rotation_order = ORD_XYZ;
        moving_axes    = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        stimulus_done  = 0;
        hold_results   = 0;
        res_valid_taken   = 1'b0;
        req_stall_at_edge = 1'b0;
        send_gap_next     = 0;

        // Directed part: every order in both modes at mixed angles, the
        // identity codes, the most negative angle negated in moving mode,
        // the field extremes, and angles that push the CORDIC past one.
        for (int o = 0; o < 8; o++)
            queue_request(ANGLE_BITS'(1000 * (o + 1)), -16'sd2500, 16'sd7000, o[2:0], o[0]);
        for (int o = 0; o < 6; o++)
            queue_request(-16'sd3000, 16'sd5000, -16'sd9000, o[2:0], ~o[0]);
        queue_request(MOST_NEG, MOST_NEG, MOST_NEG, ORD_XYZ, 1'b1);
        queue_request(MOST_POS, MOST_POS, MOST_POS, ORD_ZYX, 1'b0);
        queue_request(MOST_NEG, MOST_POS, '0, ORD_YZX, 1'b1);
        queue_request('0, '0, '0, ORD_XYZ, 1'b0);
        queue_request('0, '0, '0, ORD_IDENT_HI, 1'b1);
        queue_request(MOST_POS, MOST_NEG, MOST_POS, ORD_IDENT_LO, 1'b0);
        queue_request(16'sd6434, 16'sd6434, 16'sd6434, ORD_XZY, 1'b0);
        queue_request(-16'sd12868, 16'sd12868, -16'sd6434, ORD_ZXY, 1'b1);
        queue_request(-16'sd1, 16'sd1, -16'sd1, ORD_YXZ, 1'b0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random part, with one long receiver hold-off in the middle so the
        // pipeline fills and the core has to stall its input.
        for (int n = 0; n < 1900; n++)
        begin
            queue_request(random_angle(), random_angle(), random_angle(),
                          3'($urandom_range(0, 7)), 1'($urandom));
            if (n == 600)
            begin
                while (pending_requests.size() > 0)
                    @(posedge clk);
                hold_results = 1;
                for (int k = 0; k < 40; k++)
                    queue_request(random_angle(), random_angle(), random_angle(),
                                  3'($urandom_range(0, 5)), 1'($urandom));
                repeat (200) @(posedge clk);
                hold_results = 0;
            end
        end

        while (pending_requests.size() > 0 || expected_matrices.size() > 0)
            @(posedge clk);
        repeat (3 * (NSTEPS + 5)) @(posedge clk);

        if (mismatch_count == 0)
            $display("rotation_matrix_from_euler_angles_core regression: pass");
        else
            $display("rotation_matrix_from_euler_angles_core regression: fail");
        $finish;
    end

endmodule
